// ===== rtl/core/amrmw_pkg.sv =====
// Package for the atomic read-modify-write unit: request and result words,
// operation codes, controller states and the command/status groups.
// No dependencies.
package amrmw_pkg;

	localparam int DATA_W        = 64;
	localparam int INDEX_W       = 10;
	localparam int DEPTH_DEFAULT = 1024;
	// shift used by the reciprocal multiply that folds the index into DEPTH
	localparam int RECIP_SH      = 21;

	// operation codes; 12..15 are unassigned and reported as unsupported
	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_AND   = 4'd1,
		OP_OR    = 4'd2,
		OP_XOR   = 4'd3,
		OP_XCHG  = 4'd4,
		OP_SMAX  = 4'd5,
		OP_SMIN  = 4'd6,
		OP_UMAX  = 4'd7,
		OP_UMIN  = 4'd8,
		OP_CAS   = 4'd9,
		OP_STORE = 4'd10,
		OP_LOAD  = 4'd11
	} op_t;

	// element size codes
	typedef enum logic [1:0] {
		ES_8  = 2'd0,
		ES_16 = 2'd1,
		ES_32 = 2'd2,
		ES_64 = 2'd3
	} es_t;

	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_UNSUP = 1'b1;

	typedef struct packed {
		logic [3:0]         op;
		logic [INDEX_W-1:0] index;
		logic [DATA_W-1:0]  operand;
		logic [DATA_W-1:0]  expected;
		logic [1:0]         elem_size;
		logic               enable;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] prev_elem;
		logic              status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADDR,
		ST_READ,
		ST_EXEC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic div_step;
		logic addr_step;
		logic mem_read;
		logic exec;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_live;
		logic out_free;
	} sts_t;

	// mask of the low element bits
	function automatic logic [DATA_W-1:0] elem_mask(input logic [1:0] es);
		logic [DATA_W-1:0] m;
		case (es)
			ES_8:    m = {{(DATA_W-8){1'b0}}, 8'hFF};
			ES_16:   m = {{(DATA_W-16){1'b0}}, 16'hFFFF};
			ES_32:   m = {{(DATA_W-32){1'b0}}, 32'hFFFF_FFFF};
			default: m = {DATA_W{1'b1}};
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/core/atomic_memory_rmw_unit_top.sv =====
// Top level of the atomic read-modify-write unit: controller plus datapath.
// Depends on amrmw_pkg, amrmw_ctrl and amrmw_dp.
//
// An enabled request word is taken in idle; the index is folded into DEPTH
// (reciprocal multiply, then remainder), the single-port word memory is read
// through a register, then the operation is applied and written back as the
// result word is loaded into the output register. No new word is taken until
// that update is done. A disabled word is taken in idle and gives no result.
// The next word is accepted while a finished result still waits in the output
// register; the update of that next word waits only while the register is
// occupied and rsp_stall is high.
// The memory has no reset and no clearing pass; reading a never-written
// entry returns whatever it holds.
module atomic_memory_rmw_unit_top import amrmw_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	amrmw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memory and element ALU
	amrmw_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== rtl/core/amrmw_ctrl.sv =====
// Controller of the atomic read-modify-write unit: sequences one word
// through index folding, memory read and update. Depends on amrmw_pkg.
module amrmw_ctrl import amrmw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && sts.req_live) state_d = ST_DIV;
			end
			ST_DIV:  state_d = ST_ADDR;
			ST_ADDR: state_d = ST_READ;
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall    = 1'b0;
				cmd.load_req = req_valid;
			end
			ST_DIV:  cmd.div_step  = 1'b1;
			ST_ADDR: cmd.addr_step = 1'b1;
			ST_READ: cmd.mem_read  = 1'b1;
			ST_EXEC: cmd.exec      = sts.out_free;
			default: req_stall     = 1'b1;
		endcase
	end

endmodule

// ===== rtl/core/amrmw_dp.sv =====
// Datapath of the atomic read-modify-write unit: request latch, index fold,
// word memory, element ALU and result register. Depends on amrmw_pkg.
module amrmw_dp import amrmw_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp,
	input  cmd_t cmd,
	output sts_t sts
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
	localparam int RECIP = ((1 << RECIP_SH) + DEPTH - 1) / DEPTH;

	req_t               req_q;
	logic [INDEX_W-1:0] quot_q;
	logic [AW-1:0]      addr_q;
	logic [DATA_W-1:0]  rdata_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic [DATA_W-1:0]  mem [0:DEPTH-1];

	// status to the controller
	assign sts.req_live = req_valid && req.enable;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
	end

	// index fold, step one: quotient by reciprocal multiply
	logic [31:0] prod;
	assign prod = 32'(req_q.index) * 32'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.div_step) begin
			quot_q <= prod[RECIP_SH +: INDEX_W];
		end
	end

	// index fold, step two: remainder with one correction
	logic [MW-1:0] rem0, rem1;
	always_comb begin
		rem0 = MW'(req_q.index) - MW'(quot_q) * MW'(DEPTH);
		rem1 = (rem0 >= MW'(DEPTH)) ? rem0 - MW'(DEPTH) : rem0;
	end

	always_ff @(posedge clk) begin
		if (cmd.addr_step) begin
			addr_q <= rem1[AW-1:0];
		end
	end

	// element ALU
	logic [DATA_W-1:0] mask, top, old, val, expv, nv, new_word;
	logic              slt_ov, slt_vo, ult_ov, ult_vo, unsup, do_write;
	always_comb begin
		mask   = elem_mask(req_q.elem_size);
		top    = mask ^ (mask >> 1);
		old    = rdata_q & mask;
		val    = req_q.operand & mask;
		expv   = req_q.expected & mask;
		slt_ov = ((old ^ top) & mask) < ((val ^ top) & mask);
		slt_vo = ((val ^ top) & mask) < ((old ^ top) & mask);
		ult_ov = old < val;
		ult_vo = val < old;
		unsup  = (req_q.op > OP_LOAD) ||
			((req_q.op <= OP_UMIN) && (req_q.elem_size < ES_32));
		do_write = !unsup && (req_q.op != OP_LOAD);
		case (req_q.op)
			OP_ADD:   nv = old + val;
			OP_AND:   nv = old & val;
			OP_OR:    nv = old | val;
			OP_XOR:   nv = old ^ val;
			OP_XCHG:  nv = val;
			OP_SMAX:  nv = slt_ov ? val : old;
			OP_SMIN:  nv = slt_vo ? val : old;
			OP_UMAX:  nv = ult_ov ? val : old;
			OP_UMIN:  nv = ult_vo ? val : old;
			OP_CAS:   nv = (old == expv) ? val : old;
			OP_STORE: nv = val;
			default:  nv = old;
		endcase
		new_word = (rdata_q & ~mask) | (nv & mask);
	end

	// word memory: registered read, write-back on the update cycle
	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			rdata_q <= mem[addr_q];
		end
		if (cmd.exec && do_write) begin
			mem[addr_q] <= new_word;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.prev_elem <= unsup ? '0 : old;
			rsp_q.status    <= unsup ? STATUS_UNSUP : STATUS_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
